/* rtl/core/packet_caesar_checksum_engine_macros.svh */
// Assertion macros used by the checker of the packet Caesar/checksum engine.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef PACKET_CAESAR_CHECKSUM_ENGINE_MACROS_SVH
`define PACKET_CAESAR_CHECKSUM_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcc_pkg.sv */
package pcc_pkg;

    // Header layout (byte offsets within a packet).
    localparam logic [2:0] OFS_OP        = 3'd0;
    localparam logic [2:0] OFS_SHIFT     = 3'd1;
    localparam logic [2:0] OFS_LEN_LAST  = 3'd7;
    localparam int unsigned HDR_BYTES    = 8;

    // Alphabet constants.
    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [5:0] ALPHABET    = 6'd26;
    localparam logic [7:0] OP_DECRYPT  = 8'd1;

    // Ones'-complement value that marks a correct packet checksum.
    localparam logic [15:0] SUM_GOOD = 16'hffff;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CSUM  = 2'd1,
        ST_SHORT_LEN = 2'd2
    } t_status;

    // One result item.
    typedef struct packed {
        logic [15:0] new_checksum;
        t_status     status;
        logic        last;
        logic [7:0]  out_byte;
    } t_result;

    // 16-bit ones'-complement add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Byte modulo 26 through a reciprocal multiply (79 / 2048 is exact for 0..255).
    function automatic logic [4:0] mod26(input logic [7:0] b);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [7:0]  qx;
        logic [7:0]  rem;
        prod = {7'd0, b} * 15'd79;
        q    = prod[14:11];
        qx   = {4'd0, q} * 8'd26;
        rem  = b - qx;
        return rem[4:0];
    endfunction

endpackage

/* rtl/core/pcc_in_reg.sv */
module pcc_in_reg
    import pcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_fire;
    logic       w_accept;

    // The held byte moves on when the downstream stage can take it.
    assign w_fire     = r_valid && i_take;
    assign o_s_tready = !r_valid || i_take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register loads on every input transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_s_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* rtl/core/pcc_xform.sv */
module pcc_xform
    import pcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    // Per-packet state.
    logic [31:0] r_pos;
    logic [31:0] r_size;
    logic        r_decrypt;
    logic [4:0]  r_shift;
    logic [15:0] r_in_sum;
    logic [15:0] r_out_sum;

    logic [31:0] n_pos;
    logic [31:0] n_size;
    logic        n_decrypt;
    logic [4:0]  n_shift;
    logic [15:0] n_in_sum;
    logic [15:0] n_out_sum;

    logic        w_in_hdr;
    logic        w_at_op;
    logic        w_at_shift;
    logic        w_at_csum;
    logic        w_at_len_end;
    logic        w_past_len;
    logic [31:0] w_pos_inc;
    logic [31:0] w_size_sh;
    logic [31:0] w_size_eff;
    logic [4:0]  w_key;
    logic [7:0]  w_lower;
    logic        w_letter;
    logic [5:0]  w_rot;
    logic [5:0]  w_rot_mod;
    logic [7:0]  w_payload;
    logic [7:0]  w_out;
    logic [15:0] w_in_word;
    logic [15:0] w_out_word;
    logic [15:0] w_in_sum;
    logic [15:0] w_out_sum;
    logic        w_short;
    logic        w_end;
    logic        w_last;

    // Header position decode.
    assign w_in_hdr     = (r_pos[31:3] == 29'd0);
    assign w_at_op      = w_in_hdr && (r_pos[2:0] == OFS_OP);
    assign w_at_shift   = w_in_hdr && (r_pos[2:0] == OFS_SHIFT);
    assign w_at_csum    = w_in_hdr && (r_pos[2:1] == 2'b01);
    assign w_at_len_end = w_in_hdr && (r_pos[2:0] == OFS_LEN_LAST);
    assign w_past_len   = !w_in_hdr || w_at_len_end;
    assign w_pos_inc    = r_pos + 32'd1;

    // Length field shifts in big-endian over offsets four to seven.
    assign w_size_sh  = {r_size[23:0], i_byte};
    assign w_size_eff = w_at_len_end ? w_size_sh : r_size;

    // Decryption shifts by the complement of the key.
    always_comb begin
        if (r_decrypt && (r_shift != 5'd0)) begin
            w_key = 5'(ALPHABET - {1'b0, r_shift});
        end else begin
            w_key = r_shift;
        end
    end

    // Lowercase, then rotate letters within the alphabet.
    assign w_lower   = ((i_byte >= UPPER_A) && (i_byte <= UPPER_Z)) ? (i_byte | CASE_BIT)
                                                                     : i_byte;
    assign w_letter  = (w_lower >= LOWER_A) && (w_lower <= LOWER_Z);
    assign w_rot     = {1'b0, 5'(w_lower - LOWER_A)} + {1'b0, w_key};
    assign w_rot_mod = (w_rot >= ALPHABET) ? (w_rot - ALPHABET) : w_rot;
    assign w_payload = w_letter ? (LOWER_A + {2'd0, w_rot_mod}) : w_lower;

    // Output byte: header passes except the checksum bytes, which read zero.
    always_comb begin
        if (w_at_csum) begin
            w_out = 8'd0;
        end else if (w_in_hdr) begin
            w_out = i_byte;
        end else begin
            w_out = w_payload;
        end
    end

    // Even offsets are the high byte of a 16-bit word.
    assign w_in_word  = r_pos[0] ? {8'd0, i_byte} : {i_byte, 8'd0};
    assign w_out_word = r_pos[0] ? {8'd0, w_out}  : {w_out, 8'd0};
    assign w_in_sum   = ones_add(r_in_sum, w_in_word);
    assign w_out_sum  = ones_add(r_out_sum, w_out_word);

    // End of packet detection.
    assign w_short = w_at_len_end && (w_size_sh < 32'(HDR_BYTES));
    assign w_end   = w_past_len && (w_pos_inc == w_size_eff);
    assign w_last  = w_short || w_end;

    // Result item.
    always_comb begin
        o_result.out_byte     = w_out;
        o_result.last         = w_last;
        o_result.status       = ST_OK;
        o_result.new_checksum = 16'd0;
        if (w_short) begin
            o_result.status = ST_SHORT_LEN;
        end else if (w_end) begin
            if (w_in_sum != SUM_GOOD) begin
                o_result.status = ST_BAD_CSUM;
            end else begin
                o_result.new_checksum = ~w_out_sum;
            end
        end
    end

    // Next state: advance on each processed byte, clear after the final one.
    always_comb begin
        n_pos     = r_pos;
        n_size    = r_size;
        n_decrypt = r_decrypt;
        n_shift   = r_shift;
        n_in_sum  = r_in_sum;
        n_out_sum = r_out_sum;
        if (i_fire) begin
            if (w_last) begin
                n_pos     = 32'd0;
                n_size    = 32'd0;
                n_decrypt = 1'b0;
                n_shift   = 5'd0;
                n_in_sum  = 16'd0;
                n_out_sum = 16'd0;
            end else begin
                n_pos     = w_pos_inc;
                n_in_sum  = w_in_sum;
                n_out_sum = w_out_sum;
                if (w_at_op) begin
                    n_decrypt = (i_byte == OP_DECRYPT);
                end
                if (w_at_shift) begin
                    n_shift = mod26(i_byte);
                end
                if (w_in_hdr && r_pos[2]) begin
                    n_size = w_size_sh;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 32'd0;
            r_size    <= 32'd0;
            r_decrypt <= 1'b0;
            r_shift   <= 5'd0;
            r_in_sum  <= 16'd0;
            r_out_sum <= 16'd0;
        end else begin
            r_pos     <= n_pos;
            r_size    <= n_size;
            r_decrypt <= n_decrypt;
            r_shift   <= n_shift;
            r_in_sum  <= n_in_sum;
            r_out_sum <= n_out_sum;
        end
    end

endmodule

/* rtl/core/pcc_out_reg.sv */
module pcc_out_reg
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_ready,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [23:8] new_checksum
    output logic        o_m_tlast,   // last
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The register frees up when it is empty or its transfer completes.
    assign o_ready = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_result.new_checksum, r_result.out_byte};
    assign o_m_tlast  = r_result.last;
    assign o_m_tuser  = r_result.status;

endmodule

/* rtl/core/packet_caesar_checksum_engine.sv */
// Packet Caesar/checksum engine.
// Input stream: one packet byte per transfer on i_s_tdata, header first (op, shift,
// two checksum bytes, 32-bit big-endian length), then the payload.
// Output stream: one result per input byte. o_m_tdata carries the transformed byte
// and the new checksum, o_m_tlast marks the final byte of the packet and o_m_tuser
// carries the status (ok, bad checksum, length below eight) on that final byte.
// The new checksum is nonzero only on the final byte with status ok; it belongs at
// offset two of the packet, high byte first.
// A byte accepted into the input register moves into the result register once that
// register can take it, and its result is offered from there. Throughput: one byte
// per cycle while the receiver does not stall; the end-around adds that update both
// running sums are combinational.
// Reset empties both registers and clears all packet state; the first byte after reset is
// taken as the op byte. When the receiver stalls, the result register holds its
// transfer, the input register takes one more byte only if it was empty, and
// o_s_tready stays low while the input register is full and the output is stalled.
module packet_caesar_checksum_engine
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [23:8] new_checksum
    output logic        o_m_tlast,   // last
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_ready;
    logic       w_fire;
    t_result    w_result;

    // A byte moves from the input register into the result register.
    assign w_fire = w_in_valid && w_out_ready;

    pcc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_take     (w_out_ready),
        .o_valid    (w_in_valid),
        .o_byte     (w_in_byte)
    );

    pcc_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (w_in_byte),
        .o_result (w_result)
    );

    pcc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_result),
        .o_ready    (w_out_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* rtl/core/pcc_checker.sv */
`include "packet_caesar_checksum_engine_macros.svh"

module pcc_checker
    import pcc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [1:0]  o_m_tuser
);

    // A status other than ok is only reported on the final byte.
    `PCC_ASSERT_SAME(a_status_on_last, o_m_tvalid && (o_m_tuser != ST_OK), o_m_tlast, "status without last")

    // The new checksum is zero unless this is the final byte of a good packet.
    `PCC_ASSERT_SAME(a_csum_only_ok_last, o_m_tvalid && (!o_m_tlast || (o_m_tuser != ST_OK)), o_m_tdata[23:8] == 16'd0, "stray checksum")

    // A stalled result stays offered.
    `PCC_ASSERT_NEXT(a_valid_held, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped under stall")

    // A stalled result keeps its payload.
    `PCC_ASSERT_NEXT(a_data_held, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "result changed under stall")

endmodule

bind packet_caesar_checksum_engine pcc_checker u_pcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

/* tb/sv/packet_caesar_checksum_engine_tb.sv */
`timescale 1ns / 100ps

module packet_caesar_checksum_engine_tb;
    import pcc_pkg::*;

    localparam int RANDOM_BYTES   = 400;
    localparam int DIRECTED_ROWS  = 28;
    localparam int LONG_HOLD      = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LATENCY_SLACK  = 8;

    typedef enum {FRAME_GOOD, FRAME_BAD, FRAME_SHORT} frame_kind_e;

    // One directed byte, with a hand-written expectation where it is obvious.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        t_result    want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] in_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // [7:0] out_byte, [23:8] new_checksum
    logic        o_m_tlast;   // last
    logic [1:0]  o_m_tuser;   // [1:0] status

    // Shadow copy of the packet state used to predict each result.
    logic [31:0] pr_pos;
    logic [31:0] pr_len;
    logic        pr_decrypt;
    logic [4:0]  pr_shift;
    logic [15:0] pr_in_sum;
    logic [15:0] pr_out_sum;

    t_result     pending_results[$];
    logic [7:0]  frame[$];
    stim_row_t   directed_rows [DIRECTED_ROWS];

    int          err_count = 0;
    int          results_checked = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          ok_frames = 0;
    int          bad_frames = 0;
    int          short_frames = 0;
    int          quiet_cycles = 0;
    bit          long_hold_done = 1'b0;

    always #6 i_clk = ~i_clk;

    packet_caesar_checksum_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Ones'-complement add that wraps the carry back into bit zero.
    function automatic logic [15:0] end_around_add(input logic [15:0] acc,
                                                   input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        if (s > 17'h0ffff) begin
            s = s - 17'h0ffff;
        end
        return s[15:0];
    endfunction

    // Even offsets are the high byte of a big-endian word, odd ones the low byte.
    function automatic logic [15:0] byte_lane(input logic [31:0] pos, input logic [7:0] b);
        return pos[0] ? {8'h00, b} : {b, 8'h00};
    endfunction

    function automatic logic [7:0] rotate_alpha(input logic [7:0] c, input int k);
        int v;
        v = int'(c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            v = v + int'(CASE_BIT);
        end
        if (v >= int'(LOWER_A) && v <= int'(LOWER_Z)) begin
            v = (v - int'(LOWER_A) + k) % int'(ALPHABET) + int'(LOWER_A);
        end
        return v[7:0];
    endfunction

    function automatic void clear_predictor();
        pr_pos     = '0;
        pr_len     = '0;
        pr_decrypt = 1'b0;
        pr_shift   = '0;
        pr_in_sum  = '0;
        pr_out_sum = '0;
    endfunction

    // Advance the shadow state by one input byte and return the result it causes.
    function automatic t_result predict_byte(input logic [7:0] b);
        t_result     r;
        logic [31:0] pos;
        int          k;
        pos = pr_pos;
        r = '0;
        r.out_byte = b;
        if (pos == OFS_OP) begin
            pr_decrypt = (b == OP_DECRYPT);
        end else if (pos == OFS_SHIFT) begin
            pr_shift = 5'(b % ALPHABET);
        end else if (pos == 2 || pos == 3) begin
            r.out_byte = 8'h00;
        end else if (pos < HDR_BYTES) begin
            pr_len = {pr_len[23:0], b};
        end else begin
            k = pr_decrypt ? int'((ALPHABET - {1'b0, pr_shift}) % ALPHABET)
                           : int'(pr_shift);
            r.out_byte = rotate_alpha(b, k);
        end

        pr_in_sum  = end_around_add(pr_in_sum, byte_lane(pos, b));
        pr_out_sum = end_around_add(pr_out_sum, byte_lane(pos, r.out_byte));

        if (pos == OFS_LEN_LAST && pr_len < HDR_BYTES) begin
            r.last   = 1'b1;
            r.status = ST_SHORT_LEN;
        end else if (pos >= OFS_LEN_LAST && pos + 1 == pr_len) begin
            r.last = 1'b1;
            if (pr_in_sum != SUM_GOOD) begin
                r.status = ST_BAD_CSUM;
            end else begin
                r.new_checksum = ~pr_out_sum;
            end
        end

        if (r.last) begin
            clear_predictor();
        end else begin
            pr_pos = pos + 1;
        end
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic [7:0] b, input logic [7:0] o,
                                              input logic last, input t_status st,
                                              input logic [15:0] cs);
        stim_row_t row;
        row.in_byte           = b;
        row.typed             = 1'b1;
        row.want.out_byte     = o;
        row.want.last         = last;
        row.want.status       = st;
        row.want.new_checksum = cs;
        return row;
    endfunction

    function automatic stim_row_t predicted_row(input logic [7:0] b);
        stim_row_t row;
        row         = '0;
        row.in_byte = b;
        return row;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // Offer one byte and wait for its transfer, then record what should come out.
    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result typed_res);
        t_result guess;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        guess = predict_byte(b);
        pending_results.push_back(typed ? typed_res : guess);
        bytes_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Build one packet: header, payload and, for a good frame, a matching checksum.
    task automatic make_frame(input frame_kind_e kind);
        logic [31:0] len;
        logic [15:0] acc;
        logic [7:0]  c;
        frame.delete();
        if (kind == FRAME_SHORT) begin
            len = $urandom_range(0, 7);
        end else if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(40, 96);
        end else begin
            len = $urandom_range(8, 24);
        end

        case ($urandom_range(0, 4))
            0, 1:    frame.push_back(8'h00);
            2, 3:    frame.push_back(OP_DECRYPT);
            default: frame.push_back(8'($urandom_range(0, 255)));
        endcase
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(len[31:24]);
        frame.push_back(len[23:16]);
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);

        // Payload is mostly letters of both cases, with arbitrary bytes mixed in.
        for (int i = HDR_BYTES; i < len && kind != FRAME_SHORT; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = LOWER_A + 8'($urandom_range(0, 25));
                4, 5, 6:    c = UPPER_A + 8'($urandom_range(0, 25));
                default:    c = 8'($urandom_range(0, 255));
            endcase
            frame.push_back(c);
        end

        if (kind == FRAME_GOOD) begin
            frame[2] = 8'h00;
            frame[3] = 8'h00;
            acc = '0;
            foreach (frame[i]) begin
                acc = end_around_add(acc, byte_lane(i, frame[i]));
            end
            acc = ~acc;
            frame[2] = acc[15:8];
            frame[3] = acc[7:0];
        end
    endtask

    // Compare every output transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: tdata=%h tlast=%b tuser=%h",
                       o_m_tdata, o_m_tlast, o_m_tuser);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[7:0] !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_m_tdata[7:0]);
                    err_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_tlast);
                    err_count++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[23:8] !== want.new_checksum) begin
                    $error("new_checksum: expected %h, got %h",
                           want.new_checksum, o_m_tdata[23:8]);
                    err_count++;
                end
                results_checked++;
                if (want.last) begin
                    case (want.status)
                        ST_OK:       ok_frames++;
                        ST_BAD_CSUM: bad_frames++;
                        default:     short_frames++;
                    endcase
                end
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off.
    initial begin : result_sink
        int hold_left;
        int cyc;
        bit calm_rx;
        hold_left  = 0;
        cyc        = 0;
        calm_rx    = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                calm_rx = ($urandom_range(0, 3) == 0);
            end
            if (hold_left == 0 && !long_hold_done && results_checked >= 60) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && !calm_rx && $urandom_range(0, 4) == 0) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a long stretch with no transfer on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("packet_caesar_checksum_engine verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, random frames, drain.
    initial begin : packet_source
        int          r;
        int          random_bytes;
        bit          calm_tx;
        frame_kind_e kind;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        clear_predictor();

        // Short length with an unknown op and a shift of 26, then a good
        // checksum packet, then a decrypt with the largest shift and a bad checksum.
        directed_rows = '{
            checked_row(8'hff, 8'hff, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h1a, 8'h1a, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h5a, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'ha5, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h07, 8'h07, 1'b1, ST_SHORT_LEN, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h03, 8'h03, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h9e, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'hf3, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h00, 8'h00, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h09, 8'h09, 1'b0, ST_OK, 16'h0000),
            checked_row(8'h61, 8'h64, 1'b1, ST_OK, 16'h9bf3),
            predicted_row(8'h01),
            predicted_row(8'hff),
            predicted_row(8'h12),
            predicted_row(8'h34),
            predicted_row(8'h00),
            predicted_row(8'h00),
            predicted_row(8'h00),
            predicted_row(8'h0b),
            predicted_row(8'h41),
            predicted_row(8'h7a),
            predicted_row(8'h40)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].in_byte, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        frames_sent = 3;
        wait_drained();

        // Random frames until the byte budget is used up.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            kind = (r < 6) ? FRAME_GOOD : (r < 8) ? FRAME_BAD : FRAME_SHORT;
            make_frame(kind);
            calm_tx = ($urandom_range(0, 3) == 0);
            foreach (frame[i]) begin
                send_byte(frame[i], 1'b0, '0);
                random_bytes++;
                if (!calm_tx && $urandom_range(0, 3) == 0) begin
                    idle_gap(pick_gap());
                end
            end
            frames_sent++;
            if (frames_sent == 13) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (LATENCY_SLACK) @(posedge i_clk);

        $display("Sent %0d bytes in %0d frames; results: %0d ok, %0d bad checksum, %0d short.",
                 bytes_sent, frames_sent, ok_frames, bad_frames, short_frames);
        $display("Receiver long hold-off done: %0b; %0d result transfers checked.",
                 long_hold_done, results_checked);
        if (err_count == 0) begin
            $display("packet_caesar_checksum_engine verification clean");
        end else begin
            $display("packet_caesar_checksum_engine verification failed");
        end
        $finish;
    end

endmodule
